### design/tws_pkg.sv
// Shared types, constants and helper functions of the thermostat with safety override.
package tws_pkg;

  localparam int TEMP_W    = 12;
  localparam int SUM_W     = 14;
  localparam int CNT_W     = 3;
  localparam int DUTY_W    = 8;
  localparam int PCT_W     = 7;
  localparam int BUS_W     = 2;
  localparam int REG_IDX_W = 3;
  localparam int LIM_W     = 16;
  localparam int RECIP_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int MAG_W     = SUM_W;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam int QUOT_W    = PROD_W - FRAC_W;

  localparam int CABIN_SENSORS_DEF = 4;
  localparam int CABIN_SLOTS_MAX   = 4;
  localparam int SLOTS_PER_BUS     = 2;

  localparam logic [REG_IDX_W-1:0] REG_LEFT_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CROP_PRES   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEAT_ON     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEAT_OFF    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_ON   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_OFF  = 3'd6;

  localparam logic signed [TEMP_W-1:0] VALID_LOW   = -12'sd800;
  localparam logic signed [TEMP_W-1:0] VALID_HIGH  = 12'sd1360;
  localparam logic signed [TEMP_W-1:0] CROP_LOW    = -12'sd800;
  localparam logic signed [TEMP_W-1:0] CROP_HIGH   = 12'sd2000;
  localparam logic signed [TEMP_W-1:0] UNREAD_TEMP = -12'sd2032;

  localparam logic [BUS_W-1:0]         LEFT_COUNT_RST  = 2'd2;
  localparam logic [BUS_W-1:0]         RIGHT_COUNT_RST = 2'd2;
  localparam logic                     CROP_PRES_RST   = 1'b1;
  localparam logic signed [TEMP_W-1:0] HEAT_ON_RST     = 12'sd464;
  localparam logic signed [TEMP_W-1:0] HEAT_OFF_RST    = 12'sd496;
  localparam logic signed [TEMP_W-1:0] SAFETY_ON_RST   = 12'sd560;
  localparam logic signed [TEMP_W-1:0] SAFETY_OFF_RST  = 12'sd528;

  localparam logic [DUTY_W-1:0] DUTY_IDLE = 8'd0;
  localparam logic [DUTY_W-1:0] DUTY_LOW  = 8'd76;
  localparam logic [DUTY_W-1:0] DUTY_HIGH = 8'd191;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

  typedef struct packed {
    logic signed [TEMP_W-1:0] upper_left_temp;
    logic signed [TEMP_W-1:0] lower_left_temp;
    logic signed [TEMP_W-1:0] upper_right_temp;
    logic signed [TEMP_W-1:0] lower_right_temp;
    logic signed [TEMP_W-1:0] crop_temp;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] cabin_average;
    logic [CNT_W-1:0]         valid_count;
    logic                     controlling;
    logic                     heater_on;
    logic                     safety_active;
    logic [DUTY_W-1:0]        fan_duty;
    logic [PCT_W-1:0]         fan_percent;
  } out_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [TEMP_W-1:0]    value;
  } cfg_wr_t;

  typedef struct packed {
    logic load_in;
    logic calc_avg;
    logic calc_ctrl;
    logic load_out;
  } ctrl_cmd_t;

  // Fixed-point reciprocal of the held count; exact quotients for sums in range.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd32768;
      3'd3:    r = 17'd21846;
      3'd4:    r = 17'd16384;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] percent_of(input logic [DUTY_W-1:0] duty);
    logic [PCT_W-1:0] p;
    case (duty)
      DUTY_FULL: p = 7'd100;
      DUTY_HIGH: p = 7'd75;
      DUTY_LOW:  p = 7'd30;
      default:   p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

### design/tws_stream_if.sv
// Valid/ready channel interface carrying one payload beat.
interface tws_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### design/tws_ctrl.sv
// Sequencing state machine and output valid flag of the thermostat.
module tws_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tws_pkg::ctrl_cmd_t cmd
);
  import tws_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_CTRL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SUM;
        end
      end
      S_SUM: begin
        cmd.calc_avg = 1'b1;
        state_next   = S_CTRL;
      end
      S_CTRL: begin
        cmd.calc_ctrl = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_to_sum: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SUM))
    else $error("accepted beat did not start the sum step");

  a_sum_to_ctrl: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |=> (state == S_CTRL))
    else $error("sum step not followed by control step");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result beat raised outside the done step");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("done step left while result register was full");

endmodule

### design/tws_datapath.sv
// Configuration registers, reading store, averaging and hysteresis datapath.
module tws_datapath #(
  parameter int CABIN_SENSORS = tws_pkg::CABIN_SENSORS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tws_pkg::ctrl_cmd_t cmd,
  input  tws_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  tws_pkg::cfg_wr_t   cfg_wr,
  output tws_pkg::out_item_t out_data
);
  import tws_pkg::*;

  logic [BUS_W-1:0]         left_cnt;
  logic [BUS_W-1:0]         right_cnt;
  logic                     crop_pres;
  logic signed [TEMP_W-1:0] heat_on;
  logic signed [TEMP_W-1:0] heat_off;
  logic signed [TEMP_W-1:0] safety_on;
  logic signed [TEMP_W-1:0] safety_off;

  logic signed [TEMP_W-1:0] in_vals [CABIN_SLOTS_MAX];
  logic signed [TEMP_W-1:0] readings [CABIN_SENSORS];
  logic [CABIN_SENSORS-1:0] upd;
  logic signed [TEMP_W-1:0] crop_reading;

  logic signed [SUM_W-1:0]  held_sum;
  logic [CNT_W-1:0]         held_count;
  logic                     have_average;
  logic                     safety_flag;
  logic                     heater_flag;
  logic [DUTY_W-1:0]        fan_level;
  logic [CNT_W-1:0]         item_count;

  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         count;
  logic                     crop_in_window;
  logic                     safety_nx;
  logic signed [LIM_W-1:0]  on_lim;
  logic signed [LIM_W-1:0]  off_lim;
  logic signed [LIM_W-1:0]  sum_ext;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic                     neg;
  logic [TEMP_W-1:0]        quot;

  assign in_vals[0] = in_data.upper_left_temp;
  assign in_vals[1] = in_data.lower_left_temp;
  assign in_vals[2] = in_data.upper_right_temp;
  assign in_vals[3] = in_data.lower_right_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cnt   <= LEFT_COUNT_RST;
      right_cnt  <= RIGHT_COUNT_RST;
      crop_pres  <= CROP_PRES_RST;
      heat_on    <= HEAT_ON_RST;
      heat_off   <= HEAT_OFF_RST;
      safety_on  <= SAFETY_ON_RST;
      safety_off <= SAFETY_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_wr.index)
        REG_LEFT_COUNT:  left_cnt   <= cfg_wr.value[BUS_W-1:0];
        REG_RIGHT_COUNT: right_cnt  <= cfg_wr.value[BUS_W-1:0];
        REG_CROP_PRES:   crop_pres  <= cfg_wr.value[0];
        REG_HEAT_ON:     heat_on    <= signed'(cfg_wr.value);
        REG_HEAT_OFF:    heat_off   <= signed'(cfg_wr.value);
        REG_SAFETY_ON:   safety_on  <= signed'(cfg_wr.value);
        REG_SAFETY_OFF:  safety_off <= signed'(cfg_wr.value);
        default: ;
      endcase
    end
  end

  for (genvar gi = 0; gi < CABIN_SENSORS; gi++) begin : g_slot
    localparam int POS = gi % SLOTS_PER_BUS;
    assign upd[gi] = (gi < SLOTS_PER_BUS) ? (left_cnt > BUS_W'(POS))
                                          : (right_cnt > BUS_W'(POS));
    always_ff @(posedge clk) begin
      if (rst) begin
        readings[gi] <= UNREAD_TEMP;
      end else if (cmd.load_in && upd[gi]) begin
        readings[gi] <= in_vals[gi];
      end
    end
  end

  always_comb begin
    sum   = '0;
    count = '0;
    for (int i = 0; i < CABIN_SENSORS; i++) begin
      if (readings[i] > VALID_LOW && readings[i] < VALID_HIGH) begin
        sum   = sum + SUM_W'(readings[i]);
        count = count + CNT_W'(1);
      end
    end
  end

  assign crop_in_window = (crop_reading >= CROP_LOW) && (crop_reading <= CROP_HIGH);

  always_comb begin
    safety_nx = safety_flag;
    if (crop_in_window) begin
      if (!safety_flag && crop_reading >= safety_on) begin
        safety_nx = 1'b1;
      end else if (safety_flag && crop_reading <= safety_off) begin
        safety_nx = 1'b0;
      end
    end
  end

  assign on_lim  = LIM_W'(heat_on) * LIM_W'(signed'({1'b0, held_count}));
  assign off_lim = LIM_W'(heat_off) * LIM_W'(signed'({1'b0, held_count}));
  assign sum_ext = LIM_W'(held_sum);
  assign mag     = held_sum[SUM_W-1] ? MAG_W'(-held_sum) : MAG_W'(held_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_reading <= UNREAD_TEMP;
      held_sum     <= '0;
      held_count   <= '0;
      have_average <= 1'b0;
      safety_flag  <= 1'b0;
      heater_flag  <= 1'b0;
      fan_level    <= DUTY_IDLE;
    end else begin
      if (cmd.load_in && crop_pres) begin
        crop_reading <= in_data.crop_temp;
      end
      if (cmd.calc_avg && count != '0) begin
        held_sum     <= sum;
        held_count   <= count;
        have_average <= 1'b1;
      end
      if (cmd.calc_ctrl && have_average) begin
        safety_flag <= safety_nx;
        if (safety_nx) begin
          heater_flag <= 1'b0;
          fan_level   <= DUTY_FULL;
        end else begin
          if (sum_ext <= on_lim) begin
            heater_flag <= 1'b1;
          end else if (sum_ext >= off_lim) begin
            heater_flag <= 1'b0;
          end
          fan_level <= (sum_ext < on_lim) ? DUTY_HIGH : DUTY_LOW;
        end
      end
    end
  end

  // Average magnitude by reciprocal multiply; the sign is restored at output load.
  always_ff @(posedge clk) begin
    if (cmd.calc_avg) begin
      item_count <= count;
    end
    if (cmd.calc_ctrl) begin
      prod <= PROD_W'(mag) * PROD_W'(recip_of(held_count));
      neg  <= held_sum[SUM_W-1];
    end
  end

  assign quot = prod[FRAC_W +: TEMP_W];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.cabin_average <= neg ? signed'(~quot + TEMP_W'(1)) : signed'(quot);
      out_data.valid_count   <= item_count;
      out_data.controlling   <= have_average;
      out_data.heater_on     <= heater_flag;
      out_data.safety_active <= safety_flag;
      out_data.fan_duty      <= fan_level;
      out_data.fan_percent   <= percent_of(fan_level);
    end
  end

endmodule

### design/thermostat_with_safety_override_core.sv
// Top level of the cabin thermostat with crop overtemperature cutoff.
//
//   Channel  Dir  Payload                                   Accepted when
//   sensor   in   four cabin readings and one crop reading  sensor.valid && sensor.ready
//   result   out  average, count, heater, safety, fan       result.valid && result.ready
//   cfg      in   register index and write value            cfg.valid && cfg.ready
//
// After acceptance a beat passes the sum, control and load steps of the sequencer before its
// result is in the output register; no new beat is accepted until the sequencer is idle again.
// The next sensor beat is taken while a result still waits; the sequencer then holds in
// its last step until the output register is free. Reset is synchronous and needs no
// clearing pass. Configuration writes are taken in every cycle.
module thermostat_with_safety_override_core #(
  parameter int CABIN_SENSORS = tws_pkg::CABIN_SENSORS_DEF
) (
  input logic       clk,
  input logic       rst,
  tws_stream_if.sink   sensor,
  tws_stream_if.source result,
  tws_stream_if.sink   cfg
);
  import tws_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg.ready = 1'b1;

  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sensor.valid),
    .in_ready  (sensor.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  tws_datapath #(
    .CABIN_SENSORS (CABIN_SENSORS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (sensor.data),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_wr   (cfg.data),
    .out_data (result.data)
  );

endmodule
